// ----- rtl/core/dcrq_pkg.sv -----
// shared constants, command and status types for the divisor count range query unit
package dcrq_pkg;

    // largest number held in the tables
    localparam int LIMIT = 65535;
    localparam int DEPTH = LIMIT + 1;
    localparam int IDX_W = $clog2(DEPTH);

    // integer square root, evaluated at elaboration only
    function automatic int isqrt(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) begin
            r = r + 1;
        end
        return r;
    endfunction

    localparam int SQRT_LIMIT = isqrt(LIMIT);
    localparam int PRIME_W    = $clog2(SQRT_LIMIT + 2);
    localparam int MULT_W     = IDX_W + 1;

    // table entry widths
    localparam int EXP_W = 5;
    localparam int DIV_W = 8;

    // divider width covers both index and divisor count operands
    localparam int DVD_W = (IDX_W > DIV_W) ? IDX_W : DIV_W;

    // stream field widths
    localparam int WANT_W      = 8;
    localparam int RANGE_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int CMP_W       = (IDX_W > RANGE_W) ? IDX_W : RANGE_W;

    // controller to datapath commands
    typedef struct packed {
        logic init_write;
        logic sieve_start;
        logic prime_read;
        logic prime_next;
        logic mult_start;
        logic mult_read;
        logic mult_update;
        logic sweep_start;
        logic div_start_m;
        logic m_read;
        logic div_start_a;
        logic prod_calc;
        logic n_write_prime;
        logic n_write;
        logic q_load;
        logic scan_step;
        logic out_load;
    } dcrq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic idx_last;
        logic prime_done;
        logic is_prime;
        logic mult_done;
        logic p_is_n;
        logic div_done;
        logic q_empty;
        logic scan_last;
        logic pipe_busy;
        logic out_busy;
    } dcrq_stat_t;

endpackage

// ----- rtl/core/dcrq_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module dcrq_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dcrq_pkg::DVD_W-1:0] dividend,
    input  logic [dcrq_pkg::DVD_W-1:0] divisor,
    output logic                       done,
    output logic [dcrq_pkg::DVD_W-1:0] quotient
);
    import dcrq_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVD_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? DVD_W'(trial - {1'b0, dsr_reg}) : DVD_W'(trial);
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/dcrq_datapath.sv -----
// table memories, sieve and sweep counters, query scan and result register
module dcrq_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dcrq_pkg::dcrq_cmd_t              cmd,
    output dcrq_pkg::dcrq_stat_t             stat,
    input  logic [dcrq_pkg::WANT_W-1:0]      wanted_divisors,
    input  logic [dcrq_pkg::RANGE_W-1:0]     range_low,
    input  logic [dcrq_pkg::RANGE_W-1:0]     range_high,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dcrq_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import dcrq_pkg::*;

    // tables
    logic [IDX_W-1:0] spf_mem [DEPTH];
    logic [EXP_W-1:0] exp_mem [DEPTH];
    logic [DIV_W-1:0] dvt_mem [DEPTH];

    logic [IDX_W-1:0] spf_rd;
    logic [EXP_W-1:0] exp_rd;
    logic [DIV_W-1:0] dvt_rd;

    // build state
    logic [IDX_W-1:0]   idx_reg;
    logic [PRIME_W-1:0] prime_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic [IDX_W-1:0]   p_reg;
    logic [EXP_W-1:0]   a_reg;
    logic [DIV_W-1:0]   prod_reg;

    // query state
    logic [WANT_W-1:0]  wanted_reg;
    logic [IDX_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   hi_reg;
    logic               q_empty_reg;
    logic               rd_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_valid_reg;

    logic [IDX_W-1:0]         spf_raddr;
    logic [IDX_W-1:0]         tab_raddr;
    logic [IDX_W-1:0]         m_addr;
    logic                     spf_we;
    logic [IDX_W-1:0]         spf_waddr;
    logic [IDX_W-1:0]         spf_wdata;
    logic                     tab_we;
    logic [EXP_W-1:0]         exp_wdata;
    logic [DIV_W-1:0]         dvt_wdata;
    logic [2*PRIME_W-1:0]     prime_sq;
    logic [EXP_W-1:0]         a_calc;
    logic [EXP_W:0]           a_inc;
    logic [DIV_W+EXP_W:0]     prod_full;
    logic [CMP_W-1:0]         lo_ext;
    logic [CMP_W-1:0]         hi_ext;
    logic [CMP_W-1:0]         hi_clamp;
    logic                     div_start;
    logic [DVD_W-1:0]         div_dividend;
    logic [DVD_W-1:0]         div_divisor;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quot;
    logic                     out_busy;

    dcrq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_addr    = IDX_W'(div_quot);
    assign prime_sq  = prime_reg * prime_reg;
    assign a_calc    = (spf_rd != p_reg) ? EXP_W'(1) : exp_rd + EXP_W'(1);
    assign a_inc     = {1'b0, a_reg} + 1'b1;
    assign prod_full = div_quot[DIV_W-1:0] * a_inc;

    // n / p first, then count(m) / a
    assign div_start    = cmd.div_start_m | cmd.div_start_a;
    assign div_dividend = cmd.div_start_m ? DVD_W'(idx_reg) : DVD_W'(dvt_rd);
    assign div_divisor  = cmd.div_start_m ? DVD_W'(spf_rd) : DVD_W'(a_calc);

    always_comb begin
        spf_raddr = idx_reg;
        if (cmd.prime_read) begin
            spf_raddr = IDX_W'(prime_reg);
        end else if (cmd.mult_read) begin
            spf_raddr = IDX_W'(mult_reg);
        end else if (cmd.m_read) begin
            spf_raddr = m_addr;
        end
    end

    assign tab_raddr = cmd.m_read ? m_addr : scan_reg;

    // mark a multiple only if no smaller prime got there first
    assign spf_we    = cmd.init_write | (cmd.mult_update & (MULT_W'(spf_rd) == mult_reg));
    assign spf_waddr = cmd.init_write ? idx_reg : IDX_W'(mult_reg);
    assign spf_wdata = cmd.init_write ? ((idx_reg < IDX_W'(2)) ? '0 : idx_reg)
                                      : IDX_W'(prime_reg);

    assign tab_we = cmd.init_write | cmd.n_write_prime | cmd.n_write;

    always_comb begin
        if (cmd.init_write) begin
            exp_wdata = '0;
            dvt_wdata = (idx_reg == IDX_W'(1)) ? DIV_W'(1) : '0;
        end else if (cmd.n_write_prime) begin
            exp_wdata = EXP_W'(1);
            dvt_wdata = DIV_W'(2);
        end else begin
            exp_wdata = a_reg;
            dvt_wdata = prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (spf_we) begin
            spf_mem[spf_waddr] <= spf_wdata;
        end
        spf_rd <= spf_mem[spf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            exp_mem[idx_reg] <= exp_wdata;
            dvt_mem[idx_reg] <= dvt_wdata;
        end
        exp_rd <= exp_mem[tab_raddr];
        dvt_rd <= dvt_mem[tab_raddr];
    end

    // range clamp
    assign lo_ext   = CMP_W'(range_low);
    assign hi_ext   = CMP_W'(range_high);
    assign hi_clamp = (hi_ext > CMP_W'(LIMIT)) ? CMP_W'(LIMIT) : hi_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.sweep_start) begin
                idx_reg <= IDX_W'(2);
            end else if (cmd.init_write | cmd.n_write_prime | cmd.n_write) begin
                idx_reg <= idx_reg + 1'b1;
            end
            rd_valid_reg <= cmd.scan_step;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sieve_start) begin
            prime_reg <= PRIME_W'(2);
        end else if (cmd.prime_next) begin
            prime_reg <= prime_reg + 1'b1;
        end
        if (cmd.mult_start) begin
            mult_reg <= MULT_W'(prime_sq);
        end else if (cmd.mult_update) begin
            mult_reg <= mult_reg + MULT_W'(prime_reg);
        end
        if (cmd.div_start_m) begin
            p_reg <= spf_rd;
        end
        if (cmd.div_start_a) begin
            a_reg <= a_calc;
        end
        if (cmd.prod_calc) begin
            prod_reg <= DIV_W'(prod_full);
        end
        if (cmd.q_load) begin
            wanted_reg  <= wanted_divisors;
            scan_reg    <= IDX_W'(lo_ext);
            hi_reg      <= IDX_W'(hi_clamp);
            q_empty_reg <= lo_ext > hi_clamp;
        end else if (cmd.scan_step) begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.q_load) begin
            count_reg <= '0;
        end else if (rd_valid_reg && (dvt_rd == wanted_reg)) begin
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_count_reg <= count_reg;
        end
    end

    assign out_busy = out_valid_reg & ~m_tready;

    assign stat.idx_last   = idx_reg == IDX_W'(LIMIT);
    assign stat.prime_done = prime_reg > PRIME_W'(SQRT_LIMIT);
    assign stat.is_prime   = spf_rd == IDX_W'(prime_reg);
    assign stat.mult_done  = mult_reg > MULT_W'(LIMIT);
    assign stat.p_is_n     = (spf_rd == idx_reg) || (spf_rd < IDX_W'(2));
    assign stat.div_done   = div_done;
    assign stat.q_empty    = q_empty_reg;
    assign stat.scan_last  = scan_reg == hi_reg;
    assign stat.pipe_busy  = rd_valid_reg;
    assign stat.out_busy   = out_busy;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - COUNT_W){1'b0}}, out_count_reg};

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (!q_empty_reg && (scan_reg <= hi_reg)))
        else $error("scan address ran past the range end");

    a_mark_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mult_update |-> (mult_reg <= MULT_W'(LIMIT)))
        else $error("sieve marked beyond the table");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !out_busy)
        else $error("result loaded over a waiting result");

    a_exp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.n_write |-> (a_reg != '0))
        else $error("composite entry written with zero exponent");
`endif

endmodule

// ----- rtl/core/dcrq_ctrl.sv -----
// controller state machine: table build sequence and query scan control
module dcrq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  dcrq_pkg::dcrq_stat_t  stat,
    output dcrq_pkg::dcrq_cmd_t   cmd
);
    import dcrq_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_SV_TEST,
        ST_SV_PRIME,
        ST_SV_MRD,
        ST_SV_MUPD,
        ST_SW_RD,
        ST_SW_P,
        ST_SW_DIVM,
        ST_SW_M,
        ST_SW_DIVA,
        ST_SW_WR,
        ST_IDLE,
        ST_Q_CHK,
        ST_Q_SCAN,
        ST_Q_DRAIN,
        ST_Q_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                cmd.init_write = 1'b1;
                if (stat.idx_last) begin
                    cmd.sieve_start = 1'b1;
                    state_next      = ST_SV_TEST;
                end
            end
            ST_SV_TEST: begin
                if (stat.prime_done) begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SW_RD;
                end else begin
                    cmd.prime_read = 1'b1;
                    state_next     = ST_SV_PRIME;
                end
            end
            ST_SV_PRIME: begin
                if (stat.is_prime) begin
                    cmd.mult_start = 1'b1;
                    state_next     = ST_SV_MRD;
                end else begin
                    cmd.prime_next = 1'b1;
                    state_next     = ST_SV_TEST;
                end
            end
            ST_SV_MRD: begin
                if (stat.mult_done) begin
                    cmd.prime_next = 1'b1;
                    state_next     = ST_SV_TEST;
                end else begin
                    cmd.mult_read = 1'b1;
                    state_next    = ST_SV_MUPD;
                end
            end
            ST_SV_MUPD: begin
                cmd.mult_update = 1'b1;
                state_next      = ST_SV_MRD;
            end
            ST_SW_RD: begin
                // smallest factor of n is read at the current index
                state_next = ST_SW_P;
            end
            ST_SW_P: begin
                if (stat.p_is_n) begin
                    cmd.n_write_prime = 1'b1;
                    state_next        = stat.idx_last ? ST_IDLE : ST_SW_RD;
                end else begin
                    cmd.div_start_m = 1'b1;
                    state_next      = ST_SW_DIVM;
                end
            end
            ST_SW_DIVM: begin
                if (stat.div_done) begin
                    cmd.m_read = 1'b1;
                    state_next = ST_SW_M;
                end
            end
            ST_SW_M: begin
                cmd.div_start_a = 1'b1;
                state_next      = ST_SW_DIVA;
            end
            ST_SW_DIVA: begin
                if (stat.div_done) begin
                    cmd.prod_calc = 1'b1;
                    state_next    = ST_SW_WR;
                end
            end
            ST_SW_WR: begin
                cmd.n_write = 1'b1;
                state_next  = stat.idx_last ? ST_IDLE : ST_SW_RD;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.q_load = 1'b1;
                    state_next = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                state_next = stat.q_empty ? ST_Q_DONE : ST_Q_SCAN;
            end
            ST_Q_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_Q_DONE;
                end
            end
            ST_Q_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ----- rtl/core/divisor_count_range_query_unit.sv -----
// top level of the divisor count range query unit
//
// channel  direction  fields (lsb first)                                  width
// s_*      in         wanted_divisors[7:0] range_low[23:8] range_high[39:24]  40
// m_*      out        match_count[16:0], zero pad to 24                      24
//
// after reset the tables are built before s_tready first rises: a fill pass
// over all LIMIT+1 entries, the sieve over each candidate prime and each
// multiple visited, then the sweep over each prime and each composite, with
// two passes through the bit-serial divider per composite
// a query scans the divisor count table one entry per cycle through its
// single read port; an empty range skips the scan
// aresetn is synchronous and active low and restarts the whole build
// the result sits in an output register; a stalled m_tready holds it and the
// next query is scanned meanwhile, waiting only to load its own result
module divisor_count_range_query_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // query transfer
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // wanted_divisors[7:0], range_low[23:8], range_high[39:24]
    input  logic [dcrq_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result transfer
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // match_count[16:0], bits above are zero
    output logic [dcrq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import dcrq_pkg::*;

    dcrq_cmd_t  cmd;
    dcrq_stat_t stat;

    // unpack the query fields
    logic [WANT_W-1:0]  wanted_divisors;
    logic [RANGE_W-1:0] range_low;
    logic [RANGE_W-1:0] range_high;

    assign wanted_divisors = s_tdata[WANT_W-1:0];
    assign range_low       = s_tdata[WANT_W+RANGE_W-1:WANT_W];
    assign range_high      = s_tdata[WANT_W+2*RANGE_W-1:WANT_W+RANGE_W];

    // sequencer for build and query
    dcrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // tables, counters and result register
    dcrq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .wanted_divisors (wanted_divisors),
        .range_low       (range_low),
        .range_high      (range_high),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule
